>>> design/rit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rit_pkg;

    localparam int unsigned CFG_W     = 16;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned ELAPSED_W = 17;
    localparam int unsigned SCALED_W  = 25;
    localparam int unsigned FRAC_W    = 8;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    localparam logic [15:0] INTERVAL_RST  = 16'd1000;
    localparam logic [15:0] SCALE_RST     = 16'd256;
    localparam logic [15:0] MAX_DELTA_RST = 16'd100;
    localparam logic [15:0] LIMIT_RST     = 16'd100;
    localparam logic        FOREVER_RST   = 1'b1;
    localparam logic [15:0] IDENT_RST     = 16'd1000;

    localparam logic [IDX_W-1:0] REG_INTERVAL  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SCALE     = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAX_DELTA = 3'd2;
    localparam logic [IDX_W-1:0] REG_LIMIT     = 3'd3;
    localparam logic [IDX_W-1:0] REG_FOREVER   = 3'd4;
    localparam logic [IDX_W-1:0] REG_IDENT     = 3'd5;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        logic [15:0] interval_ms;
        logic [15:0] scale_q8_8;
        logic [15:0] max_delta_ms;
        logic [15:0] repeat_limit;
        logic        run_endless;
        logic [15:0] timer_ident;
    } cfg_t;

    typedef struct packed {
        logic                 enabled;
        logic [ELAPSED_W-1:0] elapsed;
        logic [15:0]          delta_held;
        logic [15:0]          fires;
    } state_t;

    typedef struct packed {
        logic                fired;
        logic [SCALED_W-1:0] scaled_elapsed;
        logic [15:0]         fire_id;
        logic [15:0]         last_delta;
        logic [15:0]         fire_count;
        logic                running;
    } result_t;

endpackage

`default_nettype wire

>>> design/rit_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module rit_cfg_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [rit_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [rit_pkg::CFG_W-1:0]  cfg_data,
    output rit_pkg::cfg_t                   cfg
);

    rit_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval_ms  <= rit_pkg::INTERVAL_RST;
            cfg_reg.scale_q8_8   <= rit_pkg::SCALE_RST;
            cfg_reg.max_delta_ms <= rit_pkg::MAX_DELTA_RST;
            cfg_reg.repeat_limit <= rit_pkg::LIMIT_RST;
            cfg_reg.run_endless  <= rit_pkg::FOREVER_RST;
            cfg_reg.timer_ident  <= rit_pkg::IDENT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rit_pkg::REG_INTERVAL:  cfg_reg.interval_ms  <= cfg_data;
                rit_pkg::REG_SCALE:     cfg_reg.scale_q8_8   <= cfg_data;
                rit_pkg::REG_MAX_DELTA: cfg_reg.max_delta_ms <= cfg_data;
                rit_pkg::REG_LIMIT:     cfg_reg.repeat_limit <= cfg_data;
                rit_pkg::REG_FOREVER:   cfg_reg.run_endless  <= cfg_data[0];
                rit_pkg::REG_IDENT:     cfg_reg.timer_ident  <= cfg_data;
                default:                cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> design/rit_step.sv
`timescale 1ns / 1ps
`default_nettype none

module rit_step (
    input  wire rit_pkg::cfg_t    cfg,
    input  wire rit_pkg::state_t  state,
    input  wire rit_pkg::op_t     op,
    input  wire logic [15:0]      delta_ms,
    output rit_pkg::state_t       state_next,
    output rit_pkg::result_t      result
);

    logic [15:0]                   clamped;
    logic [rit_pkg::ELAPSED_W:0]   sum;
    logic [rit_pkg::ELAPSED_W-1:0] sum_sat;
    logic                          fire;
    logic [rit_pkg::ELAPSED_W+15:0] product;
    logic [15:0]                   fires_inc;
    logic                          auto_stop;
    logic                          fired;

    always_comb
    begin
        clamped   = (delta_ms > cfg.max_delta_ms) ? cfg.max_delta_ms : delta_ms;
        sum       = {1'b0, state.elapsed} + {{(rit_pkg::ELAPSED_W-15){1'b0}}, clamped};
        sum_sat   = sum[rit_pkg::ELAPSED_W] ? rit_pkg::ELAPSED_MAX
                                            : sum[rit_pkg::ELAPSED_W-1:0];
        fire      = sum_sat > {{(rit_pkg::ELAPSED_W-16){1'b0}}, cfg.interval_ms};
        product   = {16'd0, sum_sat} * {{rit_pkg::ELAPSED_W{1'b0}}, cfg.scale_q8_8};
        fires_inc = state.fires + 16'd1;
        auto_stop = !cfg.run_endless && (fires_inc >= cfg.repeat_limit);

        state_next = state;
        fired      = 1'b0;
        case (op)
            rit_pkg::OP_TICK:
            begin
                if (state.enabled)
                begin
                    state_next.delta_held = clamped;
                    state_next.elapsed    = sum_sat;
                    if (fire)
                    begin
                        fired                 = 1'b1;
                        state_next.elapsed    = '0;
                        state_next.fires      = fires_inc;
                        if (auto_stop)
                        begin
                            state_next = '0;
                        end
                    end
                end
            end
            rit_pkg::OP_START:
            begin
                state_next.enabled = 1'b1;
            end
            rit_pkg::OP_STOP:
            begin
                state_next = '0;
            end
            default:
            begin
                state_next.elapsed    = '0;
                state_next.delta_held = '0;
                state_next.fires      = '0;
            end
        endcase

        result.fired          = fired;
        result.scaled_elapsed = fired ? product[rit_pkg::FRAC_W +: rit_pkg::SCALED_W] : '0;
        result.fire_id        = cfg.timer_ident;
        result.last_delta     = state_next.delta_held;
        result.fire_count     = state_next.fires;
        result.running        = state_next.enabled;
    end

endmodule

`default_nettype wire

>>> design/repeating_interval_timer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// input     in_valid / in_stall   op, delta_ms
// output    out_valid / out_stall fired, scaled_elapsed, fire_id, last_delta,
//                                 fire_count, running
// config    cfg_we                cfg_index, cfg_data
//
// A command is registered in the input stage and its result in the result
// register; one command is taken every cycle while in_stall is low.
// The timer state is updated in the same cycle the result register is loaded.
// Reset returns the valid flags, config and timer state to their defaults.
// A stalled output holds its result; the input stage still takes a command
// unless it already holds one that cannot move on.

module repeating_interval_timer (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output wire logic                       in_stall,
    input  wire logic [1:0]                 op,
    input  wire logic [15:0]                delta_ms,
    output wire logic                       out_valid,
    input  wire logic                       out_stall,
    output wire logic                       fired,
    output wire logic [24:0]                scaled_elapsed,
    output wire logic [15:0]                fire_id,
    output wire logic [15:0]                last_delta,
    output wire logic [15:0]                fire_count,
    output wire logic                       running,
    input  wire logic                       cfg_we,
    input  wire logic [rit_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [rit_pkg::CFG_W-1:0]  cfg_data
);

    rit_pkg::cfg_t    cfg;
    rit_pkg::state_t  state_reg;
    rit_pkg::state_t  state_next;
    rit_pkg::result_t result_reg;
    rit_pkg::result_t result_next;
    rit_pkg::op_t     op_reg;
    logic [15:0]      delta_reg;
    logic             s1_valid_reg;
    logic             out_valid_reg;
    logic             advance;

    rit_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rit_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .op         (op_reg),
        .delta_ms   (delta_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            op_reg    <= rit_pkg::op_t'(op);
            delta_reg <= delta_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign fired          = result_reg.fired;
    assign scaled_elapsed = result_reg.scaled_elapsed;
    assign fire_id        = result_reg.fire_id;
    assign last_delta     = result_reg.last_delta;
    assign fire_count     = result_reg.fire_count;
    assign running        = result_reg.running;

    // A stopped timer always has its counters cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.enabled |-> (state_reg.fires == 16'd0 && state_reg.delta_held == 16'd0
                                && state_reg.elapsed == '0))
        else $error("stopped timer holds nonzero counters");

    // The timer state only moves when a command reaches the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && s1_valid_reg) |=> $stable(state_reg))
        else $error("timer state changed without a command");

    // A result shown as stopped reports cleared counters.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !running) |-> (fire_count == 16'd0 && last_delta == 16'd0))
        else $error("stopped result reports nonzero counters");

    // The input side is held back only when a command is already waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a waiting command");

endmodule

`default_nettype wire
